/* src/dsb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsb_pkg
// Shared types and constants of the decaying sine tone burst generator.
// ----------------------------------------------------------------------------
package dsb_pkg;

    localparam int SINE_TABLE_ENTRIES_DEF = 1024;
    localparam int PHASE_BITS_DEF         = 32;

    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int LEN_W   = 16;
    localparam int AMP_W   = 15;
    localparam int SINE_W  = 15;
    localparam int SAMPLE_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE    = 2'd2;

    localparam logic [CFG_W-1:0] PHASE_STEP_RST   = 32'd42852281;
    localparam logic [LEN_W-1:0] BURST_LENGTH_RST = 16'd2646;
    localparam logic [AMP_W-1:0] AMPLITUDE_RST    = 15'd12000;

    // quotient bits of the magnitude divide
    localparam int DIV_STEPS = 15;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_POS,
        S_ADDR,
        S_TAB,
        S_MUL1,
        S_MUL2,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic pos;
        logic addr;
        logic tab;
        logic mul1;
        logic mul2;
        logic div_step;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic act;
    } t_dp_status;

endpackage

/* src/dsb_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsb_ctrl
// Sequencer: takes one item, walks the datapath through phase, table, multiply
// and divide steps (phase only outside a burst), then loads the output register.
// ----------------------------------------------------------------------------
module dsb_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    output logic                o_valid,
    input  logic                i_stall,
    input  dsb_pkg::t_dp_status i_status,
    output dsb_pkg::t_dp_cmd    o_cmd
);

    dsb_pkg::t_state r_state;
    dsb_pkg::t_state n_state;
    logic [dsb_pkg::CNT_W-1:0] r_cnt;
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dsb_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            dsb_pkg::S_IDLE: begin
                if (i_valid) n_state = dsb_pkg::S_POS;
            end
            dsb_pkg::S_POS: begin
                n_state = i_status.act ? dsb_pkg::S_ADDR : dsb_pkg::S_DONE;
            end
            dsb_pkg::S_ADDR: n_state = dsb_pkg::S_TAB;
            dsb_pkg::S_TAB:  n_state = dsb_pkg::S_MUL1;
            dsb_pkg::S_MUL1: n_state = dsb_pkg::S_MUL2;
            dsb_pkg::S_MUL2: n_state = dsb_pkg::S_DIV;
            dsb_pkg::S_DIV: begin
                if (r_cnt == dsb_pkg::CNT_W'(dsb_pkg::DIV_STEPS - 1)) begin
                    n_state = dsb_pkg::S_DONE;
                end
            end
            dsb_pkg::S_DONE: begin
                if (!r_out_valid || !i_stall) n_state = dsb_pkg::S_IDLE;
            end
            default: n_state = dsb_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.accept   = (r_state == dsb_pkg::S_IDLE) && i_valid;
        o_cmd.pos      = (r_state == dsb_pkg::S_POS);
        o_cmd.addr     = (r_state == dsb_pkg::S_ADDR);
        o_cmd.tab      = (r_state == dsb_pkg::S_TAB);
        o_cmd.mul1     = (r_state == dsb_pkg::S_MUL1);
        o_cmd.mul2     = (r_state == dsb_pkg::S_MUL2);
        o_cmd.div_step = (r_state == dsb_pkg::S_DIV);
        o_cmd.finish   = (r_state == dsb_pkg::S_DONE) && (!r_out_valid || !i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (o_cmd.mul2) begin
            r_cnt <= '0;
        end else if (o_cmd.div_step) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stall = (r_state != dsb_pkg::S_IDLE);
    assign o_valid = r_out_valid;

    a_finish_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> o_valid)
        else $error("result not presented after finish");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> (!r_out_valid || !i_stall))
        else $error("held result overwritten");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dsb_pkg::S_DIV) |-> (r_cnt < dsb_pkg::CNT_W'(dsb_pkg::DIV_STEPS)))
        else $error("divide step count overrun");

    a_accept_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == dsb_pkg::S_POS))
        else $error("accepted item not started");

endmodule

/* src/dsb_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsb_datapath
// Configuration registers, burst state, phase to sine lookup, envelope and
// amplitude multiplies, restoring divide and the output register.
// ----------------------------------------------------------------------------
module dsb_datapath #(
    parameter int SINE_TABLE_ENTRIES = dsb_pkg::SINE_TABLE_ENTRIES_DEF,
    parameter int PHASE_BITS         = dsb_pkg::PHASE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [dsb_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [dsb_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                i_restart,
    input  dsb_pkg::t_dp_cmd                    i_cmd,
    output dsb_pkg::t_dp_status                 o_status,
    output logic signed [dsb_pkg::SAMPLE_W-1:0] o_sample,
    output logic                                o_active,
    output logic                                o_last
);

    localparam int POS_W  = $clog2(SINE_TABLE_ENTRIES) + 2;
    localparam int MUL_W  = PHASE_BITS + POS_W;
    localparam int TAB_AW = $clog2(SINE_TABLE_ENTRIES + 1);
    localparam int LEN_W  = dsb_pkg::LEN_W;
    localparam int AMP_W  = dsb_pkg::AMP_W;
    localparam int SINE_W = dsb_pkg::SINE_W;
    localparam int P1_W   = SINE_W + LEN_W;
    localparam int P2_W   = P1_W + AMP_W;
    localparam int Q_W    = dsb_pkg::DIV_STEPS;
    localparam longint unsigned HalfPiQ30 = 64'd1686629713;

    // Q2.30 Taylor series through x^13, rounded to Q0.15
    function automatic logic [SINE_W-1:0] quarter_sine(input longint unsigned x);
        longint unsigned t;
        longint          s;
        longint unsigned r;
        t = x;
        s = longint'(x);
        t = (t * x) >> 30; t = (t * x) >> 30; t = t / 64'd6;   s = s - longint'(t);
        t = (t * x) >> 30; t = (t * x) >> 30; t = t / 64'd20;  s = s + longint'(t);
        t = (t * x) >> 30; t = (t * x) >> 30; t = t / 64'd42;  s = s - longint'(t);
        t = (t * x) >> 30; t = (t * x) >> 30; t = t / 64'd72;  s = s + longint'(t);
        t = (t * x) >> 30; t = (t * x) >> 30; t = t / 64'd110; s = s - longint'(t);
        t = (t * x) >> 30; t = (t * x) >> 30; t = t / 64'd156; s = s + longint'(t);
        if (s < 0) begin
            r = 64'd0;
        end else begin
            r = (longint'(s) * 64'd32767 + 64'd536870912) >> 30;
        end
        if (r > 64'd32767) r = 64'd32767;
        return SINE_W'(r);
    endfunction

    logic [SINE_W-1:0] w_tab [0:SINE_TABLE_ENTRIES];

    for (genvar k = 0; k <= SINE_TABLE_ENTRIES; k++) begin : g_tab
        if (k == SINE_TABLE_ENTRIES) begin : g_peak
            assign w_tab[k] = {SINE_W{1'b1}};
        end else begin : g_ent
            localparam longint unsigned X = (HalfPiQ30 * 64'(k)) / SINE_TABLE_ENTRIES;
            assign w_tab[k] = quarter_sine(X);
        end
    end

    logic [PHASE_BITS-1:0] r_step;
    logic [LEN_W-1:0]      r_len;
    logic [AMP_W-1:0]      r_amp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= PHASE_BITS'(dsb_pkg::PHASE_STEP_RST);
            r_len  <= dsb_pkg::BURST_LENGTH_RST;
            r_amp  <= dsb_pkg::AMPLITUDE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dsb_pkg::CFG_PHASE_STEP:   r_step <= i_cfg_data[PHASE_BITS-1:0];
                dsb_pkg::CFG_BURST_LENGTH: r_len  <= i_cfg_data[LEN_W-1:0];
                dsb_pkg::CFG_AMPLITUDE:    r_amp  <= i_cfg_data[AMP_W-1:0];
                default: ;
            endcase
        end
    end

    logic [PHASE_BITS-1:0] r_phase;
    logic [LEN_W-1:0]      r_index;
    logic                  r_running;
    logic                  r_act;
    logic                  r_is_last;
    logic [LEN_W-1:0]      w_idx_eff;

    assign w_idx_eff = i_restart ? '0 : r_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= '0;
            r_index   <= '0;
            r_running <= 1'b0;
            r_act     <= 1'b0;
            r_is_last <= 1'b0;
        end else if (i_cmd.accept) begin
            if (i_restart) begin
                r_phase   <= '0;
                r_index   <= '0;
                r_running <= 1'b1;
            end
            r_act     <= (i_restart || r_running) && (w_idx_eff < r_len);
            r_is_last <= ((LEN_W + 1)'(w_idx_eff) + 1'b1) == (LEN_W + 1)'(r_len);
        end else if (i_cmd.finish) begin
            if (r_act) begin
                r_phase <= r_phase + r_step;
                r_index <= r_index + 1'b1;
                if (r_is_last) r_running <= 1'b0;
            end else begin
                r_running <= 1'b0;
            end
        end
    end

    assign o_status.act = r_act;

    logic [MUL_W-1:0]  w_pos_prod;
    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  w_off;
    logic [1:0]        w_quad;
    logic [TAB_AW-1:0] r_addr;
    logic              r_neg;
    logic [SINE_W-1:0] r_sine;
    logic [P1_W-1:0]   r_prod1;
    logic [P2_W-1:0]   w_prod2;
    logic [LEN_W-1:0]  r_rem;
    logic [Q_W-1:0]    r_dvd;
    logic [LEN_W:0]    w_cat;
    logic              w_ge;

    assign w_pos_prod = MUL_W'(r_phase) * MUL_W'(4 * SINE_TABLE_ENTRIES);

    always_comb begin
        if (r_pos >= POS_W'(3 * SINE_TABLE_ENTRIES)) begin
            w_quad = 2'd3;
            w_off  = r_pos - POS_W'(3 * SINE_TABLE_ENTRIES);
        end else if (r_pos >= POS_W'(2 * SINE_TABLE_ENTRIES)) begin
            w_quad = 2'd2;
            w_off  = r_pos - POS_W'(2 * SINE_TABLE_ENTRIES);
        end else if (r_pos >= POS_W'(SINE_TABLE_ENTRIES)) begin
            w_quad = 2'd1;
            w_off  = r_pos - POS_W'(SINE_TABLE_ENTRIES);
        end else begin
            w_quad = 2'd0;
            w_off  = r_pos;
        end
    end

    assign w_prod2 = P2_W'(r_prod1) * P2_W'(r_amp);
    assign w_cat   = {r_rem, r_dvd[Q_W-1]};
    assign w_ge    = (w_cat >= {1'b0, r_len});

    always_ff @(posedge i_clk) begin
        if (i_cmd.pos) begin
            r_pos <= w_pos_prod[MUL_W-1:PHASE_BITS];
        end
        if (i_cmd.addr) begin
            r_neg  <= w_quad[1];
            r_addr <= w_quad[0] ? TAB_AW'(POS_W'(SINE_TABLE_ENTRIES) - w_off)
                                : TAB_AW'(w_off);
        end
        if (i_cmd.tab) begin
            r_sine <= w_tab[r_addr];
        end
        if (i_cmd.mul1) begin
            r_prod1 <= P1_W'(r_sine) * P1_W'(r_len - r_index);
        end
        // drop the 2^15 scale, then divide by length one quotient bit a step
        if (i_cmd.mul2) begin
            r_rem <= w_prod2[P2_W-1 -: LEN_W];
            r_dvd <= w_prod2[P2_W-LEN_W-1 -: Q_W];
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? LEN_W'(w_cat - {1'b0, r_len}) : w_cat[LEN_W-1:0];
            r_dvd <= {r_dvd[Q_W-2:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (r_act) begin
                o_sample <= r_neg ? (dsb_pkg::SAMPLE_W'(0) - dsb_pkg::SAMPLE_W'(r_dvd))
                                  : dsb_pkg::SAMPLE_W'(r_dvd);
            end else begin
                o_sample <= '0;
            end
            o_active <= r_act;
            o_last   <= r_act && r_is_last;
        end
    end

endmodule

/* src/decaying_sine_tone_burst.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decaying_sine_tone_burst
// Tone burst generator: quarter-wave sine lookup on a phase accumulator,
// shaped by a linear decay over the burst length and scaled by amplitude.
// ----------------------------------------------------------------------------
// Each accepted item is one sample tick and yields one result item. A tick
// inside a burst runs the phase, address, table and multiply steps and the
// 15-step restoring divide by the burst length; a tick with no burst skips
// to done. A waiting result sits in the output register while the next item
// is taken and worked on; new items are held off while one is worked on, and
// its result waits to load while the output register is full and stalled.
// ----------------------------------------------------------------------------
module decaying_sine_tone_burst #(
    parameter int SINE_TABLE_ENTRIES = dsb_pkg::SINE_TABLE_ENTRIES_DEF,
    parameter int PHASE_BITS         = dsb_pkg::PHASE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [dsb_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [dsb_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_restart,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [dsb_pkg::SAMPLE_W-1:0] o_sample,
    output logic                                o_active,
    output logic                                o_last
);

    dsb_pkg::t_dp_cmd    w_cmd;
    dsb_pkg::t_dp_status w_status;

    dsb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    dsb_datapath #(
        .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES),
        .PHASE_BITS         (PHASE_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_restart  (i_restart),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .o_sample   (o_sample),
        .o_active   (o_active),
        .o_last     (o_last)
    );

endmodule

/* bench/tb_decaying_sine_tone_burst.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_decaying_sine_tone_burst
// Self-checking bench for the tone burst generator. A queue of sample ticks
// feeds a bursty driver. Each accepted tick runs through a local model of the
// phase accumulator, the quarter-wave sine table and the decay scaling. The
// monitor compares every sample with the oldest prediction while stalling on
// a changing pattern. Register settings change between drained phases.
// ----------------------------------------------------------------------------
module tb_decaying_sine_tone_burst;

    localparam int          QUARTER      = dsb_pkg::SINE_TABLE_ENTRIES_DEF;
    localparam int          RANDOM_TICKS = 1850;
    localparam int          CYCLE_LIMIT  = 1000000;
    localparam int          MAX_REPORTS  = 40;
    localparam int          LONG_HOLD    = 400;
    localparam logic [dsb_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic signed [dsb_pkg::SAMPLE_W-1:0] sample;
        logic                                active;
        logic                                last;
    } t_tone_result;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                cfg_we = 1'b0;
    logic [dsb_pkg::CFG_IDX_W-1:0]       cfg_idx = '0;
    logic [dsb_pkg::CFG_W-1:0]           cfg_data = '0;
    logic                                tick_valid = 1'b0;
    logic                                tick_stall;
    logic                                tick_restart = 1'b0;
    logic                                smp_valid;
    logic                                smp_stall = 1'b0;
    logic signed [dsb_pkg::SAMPLE_W-1:0] smp_sample;
    logic                                smp_active;
    logic                                smp_last;

    // local copy of the registers and the burst state
    logic [dsb_pkg::CFG_W-1:0]  step_reg = dsb_pkg::PHASE_STEP_RST;
    logic [dsb_pkg::LEN_W-1:0]  len_reg  = dsb_pkg::BURST_LENGTH_RST;
    logic [dsb_pkg::AMP_W-1:0]  amp_reg  = dsb_pkg::AMPLITUDE_RST;
    logic [31:0]                tone_phase = '0;
    logic [dsb_pkg::LEN_W-1:0]  tone_index = '0;
    logic                       tone_running = 1'b0;
    logic [dsb_pkg::SINE_W-1:0] sine_rom [0:QUARTER];

    logic               pending_ticks [$];
    t_tone_result       expected_samples [$];

    int unsigned mismatch_count = 0;
    int unsigned ticks_queued = 0;
    int unsigned restarts_sent = 0;
    int unsigned samples_checked = 0;
    int unsigned active_seen = 0;
    int unsigned ends_seen = 0;
    int unsigned reg_writes = 0;
    int unsigned cycle_count = 0;
    int unsigned mon_cycles = 0;
    int unsigned gap_left = 0;
    int unsigned burst_left = 0;
    int unsigned hold_left = 0;
    int unsigned next_long_hold = 300;
    int unsigned stall_mode = 0;
    bit          sender_eager = 1'b0;

    decaying_sine_tone_burst uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_valid    (tick_valid),
        .o_stall    (tick_stall),
        .i_restart  (tick_restart),
        .o_valid    (smp_valid),
        .i_stall    (smp_stall),
        .o_sample   (smp_sample),
        .o_active   (smp_active),
        .o_last     (smp_last)
    );

    always #6 clk = ~clk;

    function automatic logic [dsb_pkg::SINE_W-1:0] quarter_sine_q15(input int unsigned k);
        longint unsigned x;
        longint unsigned term;
        longint unsigned r;
        longint          acc;
        int unsigned     n;
        x    = (HALF_PI_Q30 * k) / QUARTER;
        term = x;
        acc  = longint'(x);
        for (n = 1; n <= 6; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / ((2 * n) * (2 * n + 1));
            if (n % 2) acc = acc - longint'(term);
            else       acc = acc + longint'(term);
        end
        if (acc < 0) return '0;
        r = (longint'(acc) * 32767 + (64'd1 << 29)) >> 30;
        if (r > 32767) r = 32767;
        return r[dsb_pkg::SINE_W-1:0];
    endfunction

    function automatic t_tone_result predict_sample(input logic restart);
        t_tone_result    r;
        logic [11:0]     pos;
        logic [10:0]     rom_idx;
        longint unsigned mag;
        r = '0;
        if (restart) begin
            tone_running = 1'b1;
            tone_index   = '0;
            tone_phase   = '0;
        end
        if (!tone_running || tone_index >= len_reg) begin
            tone_running = 1'b0;
            return r;
        end
        pos     = tone_phase[31:20];
        rom_idx = pos[10] ? (11'd1024 - {1'b0, pos[9:0]}) : {1'b0, pos[9:0]};
        mag = 64'(sine_rom[rom_idx]) * 64'(len_reg - tone_index) * 64'(amp_reg);
        mag = mag / (64'(len_reg) * 64'd32768);
        r.sample = pos[11] ? 16'(64'd0 - mag) : 16'(mag);
        r.active = 1'b1;
        r.last   = (32'(tone_index) + 1 == 32'(len_reg));
        tone_phase = tone_phase + step_reg;
        tone_index = tone_index + 1'b1;
        if (r.last) tone_running = 1'b0;
        return r;
    endfunction

    // driver: bursts of items with random gaps
    always @(posedge clk) begin
        if (!rst_n) begin
            tick_valid <= 1'b0;
        end else begin
            if (tick_valid && !tick_stall) begin
                expected_samples.push_back(predict_sample(tick_restart));
                if (tick_restart) restarts_sent++;
            end
            if (!tick_valid || !tick_stall) begin
                if (gap_left != 0) begin
                    gap_left--;
                    tick_valid <= 1'b0;
                end else if (pending_ticks.size() != 0) begin
                    tick_valid   <= 1'b1;
                    tick_restart <= pending_ticks[0];
                    pending_ticks.delete(0);
                    if (burst_left != 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 15);
                        if (sender_eager || $urandom_range(0, 3) == 0) gap_left = 0;
                        else gap_left = $urandom_range(1, 40);
                    end
                end else begin
                    tick_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each sample and drive the stall pattern
    always @(posedge clk) begin
        t_tone_result exp_r;
        if (!rst_n) begin
            smp_stall <= 1'b0;
        end else begin
            if (smp_valid && !smp_stall) begin
                if (expected_samples.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: sample %0d with no tick waiting", $time, smp_sample);
                end else begin
                    exp_r = expected_samples[0];
                    expected_samples.delete(0);
                    samples_checked++;
                    if (smp_active === 1'b1) active_seen++;
                    if (smp_last === 1'b1) ends_seen++;
                    if (smp_sample !== exp_r.sample || smp_active !== exp_r.active ||
                        smp_last !== exp_r.last) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("%0t: exp %0d/%b/%b act %0d/%b/%b",
                                     $time, $signed(exp_r.sample), exp_r.active,
                                     exp_r.last, smp_sample, smp_active, smp_last);
                    end
                end
            end
            mon_cycles++;
            if (mon_cycles % 50 == 0) stall_mode = $urandom_range(0, 3);
            if (samples_checked >= next_long_hold) begin
                hold_left = LONG_HOLD;
                next_long_hold = next_long_hold + 700;
            end
            if (hold_left != 0) begin
                hold_left--;
                smp_stall <= 1'b1;
            end else begin
                case (stall_mode)
                    0: smp_stall <= 1'b0;
                    1: smp_stall <= 1'($urandom_range(0, 1));
                    2: begin
                        if ($urandom_range(0, 15) == 0) hold_left = $urandom_range(1, 30);
                        smp_stall <= 1'b0;
                    end
                    default: smp_stall <= (mon_cycles % 5) < 2;
                endcase
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d samples outstanding", $time,
                     expected_samples.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [dsb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dsb_pkg::CFG_W-1:0] data);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            dsb_pkg::CFG_PHASE_STEP:   step_reg = data;
            dsb_pkg::CFG_BURST_LENGTH: len_reg  = data[dsb_pkg::LEN_W-1:0];
            dsb_pkg::CFG_AMPLITUDE:    amp_reg  = data[dsb_pkg::AMP_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic push_ticks(input logic first, input int zeros);
        int j;
        pending_ticks.push_back(first);
        for (j = 0; j < zeros; j++) pending_ticks.push_back(1'b0);
        ticks_queued += zeros + 1;
    endtask

    // check on the falling edge so that every clocked update has settled
    task automatic wait_drained();
        do @(negedge clk);
        while (pending_ticks.size() != 0 || tick_valid || expected_samples.size() != 0);
    endtask

    // well-formed bursts with random content, some early restarts as noise
    task automatic queue_bursts(input int count);
        int   n;
        int   since;
        int   plan;
        logic restart;
        since = 0;
        plan  = $urandom_range(1, 30);
        for (n = 0; n < count; n++) begin
            if (n == 0) restart = ($urandom_range(0, 3) != 0);
            else restart = (since >= plan) || ($urandom_range(0, 39) == 0);
            if (restart) begin
                since = 0;
                plan  = int'(len_reg) + $urandom_range(0, 2);
                if ($urandom_range(0, 4) == 0) plan = $urandom_range(1, int'(len_reg) + 1);
            end
            since++;
            pending_ticks.push_back(restart);
        end
        ticks_queued += count;
    endtask

    initial begin
        int k;
        for (k = 0; k < QUARTER; k++) sine_rom[k] = quarter_sine_q15(k);
        sine_rom[QUARTER] = 15'd32767;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle tick, then a burst at reset settings
        push_ticks(1'b0, 0);
        push_ticks(1'b1, 4);
        wait_drained();

        // quarter-turn step hits every quadrant and the table ends
        write_reg(dsb_pkg::CFG_PHASE_STEP, 32'h4000_0000);
        write_reg(dsb_pkg::CFG_BURST_LENGTH, 32'd8);
        write_reg(dsb_pkg::CFG_AMPLITUDE, 32'd30000);
        push_ticks(1'b1, 8);
        wait_drained();

        // single-sample bursts with an idle tick between the restarts
        write_reg(dsb_pkg::CFG_BURST_LENGTH, 32'd1);
        push_ticks(1'b1, 1);
        push_ticks(1'b1, 0);
        wait_drained();

        // zero length, full step
        write_reg(dsb_pkg::CFG_PHASE_STEP, 32'hFFFF_FFFF);
        write_reg(dsb_pkg::CFG_BURST_LENGTH, 32'd0);
        push_ticks(1'b1, 0);
        wait_drained();

        // zero amplitude, then change settings mid-burst and shrink the length
        write_reg(dsb_pkg::CFG_AMPLITUDE, 32'd0);
        write_reg(dsb_pkg::CFG_BURST_LENGTH, 32'd20);
        push_ticks(1'b1, 2);
        wait_drained();
        write_reg(dsb_pkg::CFG_AMPLITUDE, 32'd15000);
        write_reg(dsb_pkg::CFG_PHASE_STEP, 32'h0F00_0000);
        push_ticks(1'b0, 1);
        wait_drained();
        write_reg(dsb_pkg::CFG_BURST_LENGTH, 32'd3);
        push_ticks(1'b0, 1);
        wait_drained();

        // unused register index, longest burst length
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        write_reg(dsb_pkg::CFG_BURST_LENGTH, 32'hFFFF_FFFF);
        write_reg(dsb_pkg::CFG_AMPLITUDE, 32'd30000);
        push_ticks(1'b1, 2);
        wait_drained();

        while (ticks_queued < RANDOM_TICKS + 30) begin
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 5))
                    0:       write_reg(dsb_pkg::CFG_PHASE_STEP, 32'd0);
                    1:       write_reg(dsb_pkg::CFG_PHASE_STEP, 32'hFFFF_FFFF);
                    2:       write_reg(dsb_pkg::CFG_PHASE_STEP, $urandom_range(1, 1 << 24));
                    default: write_reg(dsb_pkg::CFG_PHASE_STEP, $urandom);
                endcase
            end
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 19))
                    0:       write_reg(dsb_pkg::CFG_BURST_LENGTH, 32'd0);
                    1:       write_reg(dsb_pkg::CFG_BURST_LENGTH, 32'd65535);
                    2:       write_reg(dsb_pkg::CFG_BURST_LENGTH, $urandom_range(49, 4000));
                    default: write_reg(dsb_pkg::CFG_BURST_LENGTH, $urandom_range(1, 48));
                endcase
            end
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 5))
                    0:       write_reg(dsb_pkg::CFG_AMPLITUDE, 32'd0);
                    1:       write_reg(dsb_pkg::CFG_AMPLITUDE, 32'd30000);
                    default: write_reg(dsb_pkg::CFG_AMPLITUDE, $urandom_range(0, 30000));
                endcase
            end
            if ($urandom_range(0, 15) == 0) write_reg(CFG_UNUSED, $urandom);
            sender_eager = ($urandom_range(0, 3) == 0);
            queue_bursts($urandom_range(20, 100));
            wait_drained();
        end

        repeat (40) @(posedge clk);
        if (expected_samples.size() != 0) begin
            mismatch_count++;
            $display("%0t: %0d samples never arrived", $time, expected_samples.size());
        end
        $display("Covered %0d ticks with %0d restarts and %0d register writes.",
                 ticks_queued, restarts_sent, reg_writes);
        $display("Checked %0d samples: %0d in bursts, %0d burst ends, %0d mismatches.",
                 samples_checked, active_seen, ends_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* decaying_sine_tone_burst.f */
src/dsb_pkg.sv
src/dsb_ctrl.sv
src/dsb_datapath.sv
src/decaying_sine_tone_burst.sv
bench/tb_decaying_sine_tone_burst.sv
